>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl files, included by fault_code_log_table_unit
// needs a clock i_clk and an active-low reset i_rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/fclt_pkg.sv
// types and constants of the fault code log table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fclt_pkg;

    localparam int CODE_W     = 16;
    localparam int STATUS_W   = 8;
    localparam int KIND_W     = 3;
    localparam int TIME_W     = 32;
    localparam int SPACE_W    = 16;
    localparam int COUNT_W    = 8;
    localparam int ERR_W      = 2;
    localparam int ACT_W      = 3;
    localparam int BYTES_W    = 5;

    localparam int KNOWN_CODES = 6;
    localparam int KNOWN_IW    = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_A  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_EN = 3'd6;

    // status encodings
    localparam logic [STATUS_W-1:0] ST_INACTIVE = 8'h00;
    localparam logic [STATUS_W-1:0] ST_ACTIVE   = 8'h01;
    localparam logic [STATUS_W-1:0] ST_PENDING  = 8'h02;

    localparam logic [STATUS_W-1:0] RESP_ID     = 8'h59;
    localparam logic [COUNT_W-1:0]  COUNT_MAX   = 8'hFF;
    localparam logic [BYTES_W-1:0]  HDR_BYTES   = 5'd2;
    localparam logic [BYTES_W-1:0]  ENTRY_BYTES = 5'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_REPORT     = 3'd0,
        KIND_CLEAR_ALL  = 3'd1,
        KIND_CLEAR_ONE  = 3'd2,
        KIND_RESTART    = 3'd3,
        KIND_SET_STATUS = 3'd4,
        KIND_READ       = 3'd5
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNKNOWN   = 2'd1,
        ERR_FULL      = 2'd2,
        ERR_NOT_FOUND = 2'd3
    } t_err;

    typedef struct packed {
        logic                ok;
        logic [ERR_W-1:0]    error;
        logic [ACT_W-1:0]    live_count;
        logic [COUNT_W-1:0]  occurrences;
        logic [CODE_W-1:0]   entry_code;
        logic [STATUS_W-1:0] entry_status;
        logic [BYTES_W-1:0]  byte_total;
        logic                last;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/fclt_in_if.sv
// input item channel of the fault code log table
// depends on fclt_pkg
`timescale 1ns / 1ps
`default_nettype none

interface fclt_in_if;
    import fclt_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [CODE_W-1:0]   code;
    logic [STATUS_W-1:0] status_wr;
    logic [TIME_W-1:0]   now_ms;
    logic [SPACE_W-1:0]  space;

    modport source (output valid, kind, code, status_wr, now_ms, space, input ready);
    modport sink   (input valid, kind, code, status_wr, now_ms, space, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fclt_out_if.sv
// result item channel of the fault code log table
// depends on fclt_pkg
`timescale 1ns / 1ps
`default_nettype none

interface fclt_out_if;
    import fclt_pkg::*;

    logic                valid;
    logic                ready;
    logic                ok;
    logic [ERR_W-1:0]    error;
    logic [ACT_W-1:0]    live_count;
    logic [COUNT_W-1:0]  occurrences;
    logic [CODE_W-1:0]   entry_code;
    logic [STATUS_W-1:0] entry_status;
    logic [BYTES_W-1:0]  byte_total;
    logic                last;

    modport source (output valid, ok, error, live_count, occurrences, entry_code,
                    entry_status, byte_total, last, input ready);
    modport sink   (input valid, ok, error, live_count, occurrences, entry_code,
                    entry_status, byte_total, last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fault_code_log_table_unit.sv
// fault code log table: slot store, known-code registers and the scan sequencer
// depends on fclt_pkg, fclt_in_if, fclt_out_if and assert_macros.svh
// one item at a time, ready only in idle; one slot or known code per cycle unless the output stalls
//   report fault: slot scan, known-code scan, result
//   clear one / set status: slot scan, update, result; restart: slot scan, result; clear all: result
//   read report: count pass, header, list pass, plus output stalls
// reset: config, fill, active flags and handshake cleared; slot payload not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fault_code_log_table_unit #(
    parameter int ENTRIES = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fclt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fclt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    fclt_in_if.sink                           i_in,
    fclt_out_if.source                        o_out
);
    import fclt_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW = $clog2(ENTRIES + 1);

    // one-hot sequencer states
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010,   // walk used slots with the shared comparator
        S_KNOWN = 8'b0000_0100,   // walk known-code registers with the same comparator
        S_APPLY = 8'b0000_1000,   // update the slot found by the scan
        S_COUNT = 8'b0001_0000,   // report pass one: how many slots fit
        S_HEAD  = 8'b0010_0000,   // report header item
        S_LIST  = 8'b0100_0000,   // report pass two: one item per listed slot
        S_RESP  = 8'b1000_0000    // single result item
    } t_state;

    // configuration
    logic [CODE_W-1:0]      r_known [KNOWN_CODES];
    logic [KNOWN_CODES-1:0] r_known_en;

    // slot store
    logic [CODE_W-1:0]   r_slot_code   [ENTRIES];
    logic [STATUS_W-1:0] r_slot_status [ENTRIES];
    logic [COUNT_W-1:0]  r_slot_count  [ENTRIES];
    logic [TIME_W-1:0]   r_slot_last   [ENTRIES];
    logic [ENTRIES-1:0]  r_active, n_active;
    logic [FW-1:0]       r_fill, n_fill;

    // latched item
    logic [KIND_W-1:0]   r_kind;
    logic [CODE_W-1:0]   r_code;
    logic [STATUS_W-1:0] r_nst;
    logic [TIME_W-1:0]   r_now;
    logic [SPACE_W-1:0]  r_space;

    // sequencer
    t_state              r_state, n_state;
    logic [FW-1:0]       r_idx, n_idx;       // slot pointer, may reach fill
    logic [KNOWN_IW-1:0] r_j, n_j;           // known-code pointer
    logic [BYTES_W-1:0]  r_total, n_total;   // running report length
    logic [FW-1:0]       r_n, n_n;           // slots picked for the report
    logic [FW-1:0]       r_k, n_k;           // slots already listed
    logic                r_rok, n_rok;
    t_err                r_rerr, n_rerr;
    logic [COUNT_W-1:0]  r_rocc, n_rocc;

    // output register
    logic    r_ovalid, n_ovalid;
    t_result r_out;
    t_result res;
    logic    out_load;
    logic    out_free;

    // slot write strobes
    logic                w_code, w_status, w_count, w_last;
    logic [STATUS_W-1:0] w_status_val;
    logic [COUNT_W-1:0]  w_count_val;

    logic                in_acc;
    logic [IW-1:0]       sel;
    logic [CODE_W-1:0]   rd_code;
    logic [STATUS_W-1:0] rd_status;
    logic [COUNT_W-1:0]  rd_count;
    logic                rd_active;
    logic [CODE_W-1:0]   cmp_a;
    logic                eq;
    logic                at_end;
    logic                fits;
    logic [COUNT_W-1:0]  inc_count;
    logic [ACT_W-1:0]    act_cnt;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_out.ready;

    // all slot reads go through the single pointer
    assign sel       = r_idx[IW-1:0];
    assign rd_code   = r_slot_code[sel];
    assign rd_status = r_slot_status[sel];
    assign rd_count  = r_slot_count[sel];
    assign rd_active = r_active[sel];

    // shared code comparator: slot code while scanning, known code otherwise
    assign cmp_a = (r_state == S_KNOWN) ? r_known[r_j] : rd_code;
    assign eq    = (cmp_a == r_code);

    assign at_end    = (r_idx == r_fill);
    assign fits      = (SPACE_W'(r_total) + SPACE_W'(ENTRY_BYTES)) <= r_space;
    assign inc_count = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_W'(1);
    assign act_cnt   = ACT_W'($countones(r_active));

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_j          = r_j;
        n_total      = r_total;
        n_n          = r_n;
        n_k          = r_k;
        n_rok        = r_rok;
        n_rerr       = r_rerr;
        n_rocc       = r_rocc;
        n_fill       = r_fill;
        n_active     = r_active;
        w_code       = 1'b0;
        w_status     = 1'b0;
        w_count      = 1'b0;
        w_last       = 1'b0;
        w_status_val = ST_INACTIVE;
        w_count_val  = rd_count;
        out_load     = 1'b0;
        res          = '0;
        res.live_count = act_cnt;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx   = '0;
                    n_j     = '0;
                    n_total = HDR_BYTES;
                    n_n     = '0;
                    n_k     = '0;
                    n_rok   = 1'b0;
                    n_rerr  = ERR_NONE;
                    n_rocc  = '0;
                    case (i_in.kind)
                        KIND_REPORT, KIND_CLEAR_ONE, KIND_RESTART, KIND_SET_STATUS: begin
                            n_state = S_SCAN;
                        end
                        KIND_CLEAR_ALL: begin
                            // slot payload becomes unreachable once fill is zero
                            n_fill   = '0;
                            n_active = '0;
                            n_rok    = 1'b1;
                            n_state  = S_RESP;
                        end
                        KIND_READ: begin
                            if (i_in.space < SPACE_W'(ENTRY_BYTES)) begin
                                n_state = S_RESP;
                            end else begin
                                n_state = S_COUNT;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (r_kind == KIND_RESTART) begin
                    if (at_end) begin
                        n_rok   = 1'b1;
                        n_state = S_RESP;
                    end else begin
                        if (rd_status == ST_ACTIVE) begin
                            w_status     = 1'b1;
                            w_status_val = ST_PENDING;
                        end
                        n_idx = r_idx + FW'(1);
                    end
                end else if (at_end) begin
                    // code not in the table
                    if (r_kind != KIND_REPORT) begin
                        n_rerr  = ERR_NOT_FOUND;
                        n_state = S_RESP;
                    end else if (r_fill == FW'(ENTRIES)) begin
                        n_rerr  = ERR_FULL;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_KNOWN;
                    end
                end else if (eq) begin
                    // lowest matching slot wins, pointer stays on it
                    n_state = S_APPLY;
                end else begin
                    n_idx = r_idx + FW'(1);
                end
            end

            S_KNOWN: begin
                if (r_known_en[r_j] && eq) begin
                    // append at the slot right after the used ones
                    w_code       = 1'b1;
                    w_status     = 1'b1;
                    w_status_val = ST_ACTIVE;
                    w_count      = 1'b1;
                    w_count_val  = COUNT_W'(1);
                    w_last       = 1'b1;
                    n_active[sel] = 1'b1;
                    n_fill       = r_fill + FW'(1);
                    n_rok        = 1'b1;
                    n_rocc       = COUNT_W'(1);
                    n_state      = S_RESP;
                end else if (r_j == KNOWN_IW'(KNOWN_CODES - 1)) begin
                    n_rerr  = ERR_UNKNOWN;
                    n_state = S_RESP;
                end else begin
                    n_j = r_j + KNOWN_IW'(1);
                end
            end

            S_APPLY: begin
                n_rok   = 1'b1;
                n_state = S_RESP;
                if (r_kind == KIND_REPORT) begin
                    w_count     = 1'b1;
                    w_count_val = inc_count;
                    w_last      = 1'b1;
                    n_rocc      = inc_count;
                end else if (r_kind == KIND_CLEAR_ONE) begin
                    n_active[sel] = 1'b0;
                    w_status      = 1'b1;
                    w_status_val  = ST_INACTIVE;
                end else begin
                    w_status     = 1'b1;
                    w_status_val = r_nst;
                    w_last       = 1'b1;
                end
            end

            S_COUNT: begin
                if (at_end || !fits) begin
                    n_idx   = '0;
                    n_k     = '0;
                    n_state = S_HEAD;
                end else begin
                    if (rd_active) begin
                        n_total = r_total + ENTRY_BYTES;
                        n_n     = r_n + FW'(1);
                    end
                    n_idx = r_idx + FW'(1);
                end
            end

            S_HEAD: begin
                res.ok           = 1'b1;
                res.entry_status = RESP_ID;
                res.byte_total   = r_total;
                res.last         = (r_n == '0);
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = (r_n == '0) ? S_IDLE : S_LIST;
                end
            end

            S_LIST: begin
                res.ok           = 1'b1;
                res.entry_code   = rd_code;
                res.entry_status = rd_status;
                res.byte_total   = r_total;
                res.last         = ((r_k + FW'(1)) == r_n);
                if (!rd_active) begin
                    n_idx = r_idx + FW'(1);
                end else if (out_free) begin
                    out_load = 1'b1;
                    n_idx    = r_idx + FW'(1);
                    n_k      = r_k + FW'(1);
                    if (res.last) begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_RESP: begin
                res.ok          = r_rok;
                res.error       = r_rerr;
                res.occurrences = r_rocc;
                res.last        = 1'b1;
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_ovalid = 1'b1;
        end else if (o_out.ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_j      <= '0;
            r_total  <= '0;
            r_n      <= '0;
            r_k      <= '0;
            r_rok    <= 1'b0;
            r_rerr   <= ERR_NONE;
            r_rocc   <= '0;
            r_fill   <= '0;
            r_active <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_j      <= n_j;
            r_total  <= n_total;
            r_n      <= n_n;
            r_k      <= n_k;
            r_rok    <= n_rok;
            r_rerr   <= n_rerr;
            r_rocc   <= n_rocc;
            r_fill   <= n_fill;
            r_active <= n_active;
            r_ovalid <= n_ovalid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KNOWN_CODES; i++) begin
                r_known[i] <= '0;
            end
            r_known_en <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_KNOWN_EN) begin
                r_known_en <= i_cfg_data[KNOWN_CODES-1:0];
            end else if (i_cfg_idx < CFG_KNOWN_EN) begin
                r_known[i_cfg_idx - CFG_KNOWN_A] <= i_cfg_data[CODE_W-1:0];
            end
        end
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind  <= i_in.kind;
            r_code  <= i_in.code;
            r_nst   <= i_in.status_wr;
            r_now   <= i_in.now_ms;
            r_space <= i_in.space;
        end
    end

    // slot store, written only at the pointer
    always_ff @(posedge i_clk) begin
        if (w_code) begin
            r_slot_code[sel] <= r_code;
        end
        if (w_status) begin
            r_slot_status[sel] <= w_status_val;
        end
        if (w_count) begin
            r_slot_count[sel] <= w_count_val;
        end
        if (w_last) begin
            r_slot_last[sel] <= r_now;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= res;
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.ok           = r_out.ok;
    assign o_out.error        = r_out.error;
    assign o_out.live_count   = r_out.live_count;
    assign o_out.occurrences  = r_out.occurrences;
    assign o_out.entry_code   = r_out.entry_code;
    assign o_out.entry_status = r_out.entry_status;
    assign o_out.byte_total   = r_out.byte_total;
    assign o_out.last         = r_out.last;

    // last-seen time is kept for every used slot but not reported
    logic unused_last;
    assign unused_last = ^r_slot_last[sel];

    `ASSERT_NEXT(a_busy_after_accept, in_acc, !i_in.ready, "item accepted while busy")
    `ASSERT_IMPLY(a_no_overwrite, out_load, !r_ovalid || o_out.ready, "result overwritten")
    `ASSERT_ALWAYS(a_active_in_fill, (r_active >> r_fill) == '0, "active flag beyond fill")
    `ASSERT_IMPLY(a_fill_step, r_fill != $past(r_fill),
        (r_fill == '0) || (r_fill == $past(r_fill) + FW'(1)), "fill jumped")

endmodule

`default_nettype wire

>>> dv/fclt_log_monitor.sv
// result checking for the fault code log table: tracks the log, predicts every result
// depends on fclt_pkg, fclt_in_if and fclt_out_if
`timescale 1ns / 1ps

module fclt_log_monitor #(
    parameter int ENTRIES = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fclt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fclt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    fclt_in_if                              i_req,
    fclt_out_if                             i_rsp,
    output int                              o_fail_count,
    output int                              o_pending
);
    import fclt_pkg::*;

    logic [CODE_W-1:0]      known_code [KNOWN_CODES];
    logic [KNOWN_CODES-1:0] known_mask;

    // log contents; timestamps never reach an output, so they are not kept
    logic [CODE_W-1:0]   log_code   [ENTRIES];
    logic [STATUS_W-1:0] log_status [ENTRIES];
    logic                log_live   [ENTRIES];
    logic [COUNT_W-1:0]  log_count  [ENTRIES];
    int                  log_used;

    t_result results_due [$];
    int      mismatches;

    function automatic int find_slot(input logic [CODE_W-1:0] code);
        for (int i = 0; i < log_used; i++) begin
            if (log_code[i] == code) return i;
        end
        return -1;
    endfunction

    function automatic bit code_known(input logic [CODE_W-1:0] code);
        for (int j = 0; j < KNOWN_CODES; j++) begin
            if (known_mask[j] && known_code[j] == code) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_result base_result();
        t_result r;
        int      n;
        r = '0;
        n = 0;
        for (int i = 0; i < log_used; i++) begin
            if (log_live[i]) n++;
        end
        r.live_count = ACT_W'(n);
        r.last = 1'b1;
        return r;
    endfunction

    task automatic wipe_log();
        for (int i = 0; i < ENTRIES; i++) begin
            log_code[i]   = '0;
            log_status[i] = ST_INACTIVE;
            log_live[i]   = 1'b0;
            log_count[i]  = '0;
        end
        log_used = 0;
    endtask

    task automatic predict(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code,
                           input logic [STATUS_W-1:0] nst, input logic [SPACE_W-1:0] space);
        int                 slot;
        int                 total;
        int                 picks [$];
        t_result            r;
        logic               ok;
        t_err               err;
        logic [COUNT_W-1:0] occ;
        slot = find_slot(code);
        ok   = 1'b0;
        err  = ERR_NONE;
        occ  = '0;
        if (kind == KIND_READ) begin
            r = base_result();
            if (space >= ENTRY_BYTES) begin
                // list active entries in slot order while the next one still fits
                total = HDR_BYTES;
                for (int i = 0; i < log_used && total + ENTRY_BYTES <= space; i++) begin
                    if (log_live[i]) begin
                        picks.push_back(i);
                        total += ENTRY_BYTES;
                    end
                end
                r.ok           = 1'b1;
                r.entry_status = RESP_ID;
                r.byte_total   = BYTES_W'(total);
                r.last         = (picks.size() == 0);
                results_due.push_back(r);
                foreach (picks[k]) begin
                    r.entry_code   = log_code[picks[k]];
                    r.entry_status = log_status[picks[k]];
                    r.last         = (k == picks.size() - 1);
                    results_due.push_back(r);
                end
            end else begin
                results_due.push_back(r);
            end
        end else begin
            case (kind)
                KIND_REPORT: begin
                    if (slot >= 0) begin
                        if (log_count[slot] != COUNT_MAX) log_count[slot] = log_count[slot] + 1'b1;
                        ok  = 1'b1;
                        occ = log_count[slot];
                    end else if (log_used >= ENTRIES) begin
                        err = ERR_FULL;
                    end else if (!code_known(code)) begin
                        err = ERR_UNKNOWN;
                    end else begin
                        log_code[log_used]   = code;
                        log_status[log_used] = ST_ACTIVE;
                        log_live[log_used]   = 1'b1;
                        log_count[log_used]  = COUNT_W'(1);
                        log_used++;
                        ok  = 1'b1;
                        occ = COUNT_W'(1);
                    end
                end
                KIND_CLEAR_ALL: begin
                    wipe_log();
                    ok = 1'b1;
                end
                KIND_CLEAR_ONE: begin
                    if (slot < 0) begin
                        err = ERR_NOT_FOUND;
                    end else begin
                        log_live[slot]   = 1'b0;
                        log_status[slot] = ST_INACTIVE;
                        ok = 1'b1;
                    end
                end
                KIND_RESTART: begin
                    for (int i = 0; i < log_used; i++) begin
                        if (log_status[i] == ST_ACTIVE) log_status[i] = ST_PENDING;
                    end
                    ok = 1'b1;
                end
                KIND_SET_STATUS: begin
                    if (slot < 0) begin
                        err = ERR_NOT_FOUND;
                    end else begin
                        log_status[slot] = nst;
                        ok = 1'b1;
                    end
                end
                default: ;
            endcase
            r = base_result();
            r.ok          = ok;
            r.error       = err;
            r.occurrences = occ;
            results_due.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            wipe_log();
            foreach (known_code[j]) known_code[j] = '0;
            known_mask = '0;
            results_due.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx < CFG_KNOWN_EN) begin
                    known_code[i_cfg_idx - CFG_KNOWN_A] = i_cfg_data;
                end else if (i_cfg_idx == CFG_KNOWN_EN) begin
                    known_mask = i_cfg_data[KNOWN_CODES-1:0];
                end
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result with nothing expected, actual ok %0h error %0h code %0h",
                             $time, i_rsp.ok, i_rsp.error, i_rsp.entry_code);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("ok", want.ok, i_rsp.ok);
                    check_field("error", want.error, i_rsp.error);
                    check_field("live_count", want.live_count, i_rsp.live_count);
                    check_field("occurrences", want.occurrences, i_rsp.occurrences);
                    check_field("entry_code", want.entry_code, i_rsp.entry_code);
                    check_field("entry_status", want.entry_status, i_rsp.entry_status);
                    check_field("byte_total", want.byte_total, i_rsp.byte_total);
                    check_field("last", want.last, i_rsp.last);
                end
            end
            if (i_req.valid && i_req.ready) begin
                predict(i_req.kind, i_req.code, i_req.status_wr, i_req.space);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= results_due.size();
    end

endmodule

>>> dv/tb_fault_code_log_table_unit.sv
// testbench top of the fault code log table: clock, reset, stimulus and verdict
// depends on fclt_pkg, fclt_in_if, fclt_out_if, fclt_log_monitor and the block itself
`timescale 1ns / 1ps

module tb_fault_code_log_table_unit;
    import fclt_pkg::*;

    localparam int ENTRIES      = 6;
    localparam int STALL_LIMIT  = 3000;   // cycles with no item moving on either side
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off to back the block up
    localparam int DRAIN_CYCLES = 4 * ENTRIES + 8;
    localparam int PHASE_ITEMS  = 18;
    localparam int HOT_REPORTS  = 258;    // enough to drive one count into saturation at 255

    // kinds with no operation behind them
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [CODE_W-1:0]   code;
        logic [STATUS_W-1:0] status;
        logic [TIME_W-1:0]   now_ms;
        logic [SPACE_W-1:0]  space;
    } t_fault_cmd;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fclt_in_if  fault_req ();
    fclt_out_if fault_rsp ();

    int fail_count;
    int results_pending;

    // idling knobs, in percent per cycle
    int idle_pct;
    int stall_pct;
    int hold_asks;

    // codes currently loaded, so most random items name a code the log knows about
    logic [KNOWN_CODES-1:0][CODE_W-1:0] code_reg;

    fault_code_log_table_unit #(
        .ENTRIES(ENTRIES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (fault_req),
        .o_out      (fault_rsp)
    );

    fclt_log_monitor #(
        .ENTRIES(ENTRIES)
    ) i_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_req        (fault_req),
        .i_rsp        (fault_rsp),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // one item with a fresh random timestamp
    function automatic t_fault_cmd mk(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code,
                                      input logic [STATUS_W-1:0] status,
                                      input logic [SPACE_W-1:0] space);
        t_fault_cmd c;
        c.kind   = kind;
        c.code   = code;
        c.status = status;
        c.now_ms = $urandom;
        c.space  = space;
        return c;
    endfunction

    // mostly a loaded code (enabled or not), sometimes any code at all
    function automatic logic [CODE_W-1:0] pick_code();
        if ($urandom_range(3) != 0) return code_reg[KNOWN_IW'($urandom_range(KNOWN_CODES - 1))];
        return CODE_W'($urandom);
    endfunction

    // well-formed items with random content, plus a tail of raw noise
    function automatic t_fault_cmd random_cmd(input bit allow_wipe);
        t_fault_cmd c;
        int         roll;
        c    = mk(KIND_REPORT, pick_code(), STATUS_W'($urandom), '0);
        roll = $urandom_range(99);
        if (roll < 40) begin
            c.kind = KIND_REPORT;
        end else if (roll < 48) begin
            c.kind = KIND_CLEAR_ONE;
        end else if (roll < 57) begin
            c.kind = KIND_SET_STATUS;
            // re-arming to active gives restart something to turn pending
            if ($urandom_range(2) == 0) c.status = ST_ACTIVE;
        end else if (roll < 64) begin
            c.kind = KIND_RESTART;
        end else if (roll < 84) begin
            c.kind  = KIND_READ;
            // small capacities sit on the cut-off between listed and dropped entries
            c.space = ($urandom_range(3) != 0) ? SPACE_W'($urandom_range(0, 22))
                                               : SPACE_W'($urandom);
        end else if (roll < 88) begin
            c.kind = allow_wipe ? KIND_CLEAR_ALL : KIND_REPORT;
        end else if (roll < 93) begin
            c.kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
        end else begin
            c.kind  = KIND_W'($urandom);
            c.code  = CODE_W'($urandom);
            c.space = SPACE_W'($urandom);
            if (!allow_wipe && c.kind == KIND_CLEAR_ALL) c.kind = KIND_READ;
        end
        return c;
    endfunction

    // offer one item, with a random gap first in the idling phases
    task automatic send(input t_fault_cmd c);
        if ($urandom_range(99) < idle_pct) begin
            fault_req.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        fault_req.valid      <= 1'b1;
        fault_req.kind       <= c.kind;
        fault_req.code       <= c.code;
        fault_req.status_wr  <= c.status;
        fault_req.now_ms     <= c.now_ms;
        fault_req.space      <= c.space;
        @(posedge i_clk);
        while (!fault_req.ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // all six code registers, then the enable mask
    task automatic load_config(input logic [KNOWN_CODES-1:0][CODE_W-1:0] codes,
                               input logic [KNOWN_CODES-1:0] enable);
        for (int j = 0; j < KNOWN_CODES; j++) begin
            write_reg(CFG_IDX_W'(CFG_KNOWN_A + j), codes[j]);
        end
        write_reg(CFG_KNOWN_EN, CFG_DATA_W'(enable));
        i_cfg_we <= 1'b0;
        code_reg = codes;
    endtask

    // stop offering and wait for every expected result, then for the extra quiet cycles asked for
    task automatic settle(input int extra);
        fault_req.valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // receiver: random stalls, plus a long hold-off whenever one is asked for
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        fault_rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                fault_rsp.ready <= 1'b0;
                hold_left--;
            end else begin
                fault_rsp.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // watchdog: too long with nothing moving means the block hung
    initial begin
        int stuck;
        stuck = 0;
        wait (i_rst_n === 1'b1);
        while (stuck < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((fault_req.valid && fault_req.ready) || (fault_rsp.valid && fault_rsp.ready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [KNOWN_CODES-1:0][CODE_W-1:0] codes;
        logic [CODE_W-1:0]                  hot;
        int                                 hot_sent;

        idle_pct  = 0;
        stall_pct = 0;
        hold_asks = 0;
        code_reg  = '0;

        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= '0;
        i_cfg_data           <= '0;
        fault_req.valid      <= 1'b0;
        fault_req.kind       <= KIND_REPORT;
        fault_req.code       <= '0;
        fault_req.status_wr  <= '0;
        fault_req.now_ms     <= '0;
        fault_req.space      <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling
        // code extremes, a duplicated code and one code left disabled (f down to a)
        load_config({16'h5A5A, 16'hBEEF, 16'h1234, 16'h1234, 16'hFFFF, 16'h0000}, 6'b101111);
        send(mk(KIND_READ, 16'h0000, 8'h00, 16'd0));          // no room at all
        send(mk(KIND_READ, 16'h0000, 8'h00, 16'd20));         // empty log, header only
        send(mk(KIND_REPORT, 16'h7777, 8'h00, 16'd0));        // not a known code
        send(mk(KIND_REPORT, 16'h0000, 8'h00, 16'd0));
        send(mk(KIND_REPORT, 16'hFFFF, 8'h00, 16'd0));
        send(mk(KIND_REPORT, 16'hBEEF, 8'h00, 16'd0));        // known but disabled
        send(mk(KIND_REPORT, 16'h1234, 8'h00, 16'd0));        // code loaded twice
        send(mk(KIND_REPORT, 16'h0000, 8'h00, 16'd0));        // repeat bumps the count
        send(mk(KIND_CLEAR_ONE, 16'h9999, 8'h00, 16'd0));     // not in the log
        send(mk(KIND_SET_STATUS, 16'hFFFF, 8'hFF, 16'd0));
        send(mk(KIND_SET_STATUS, 16'h4321, 8'h00, 16'd0));    // not in the log
        send(mk(KIND_RESTART, 16'h0000, 8'h00, 16'd0));
        send(mk(KIND_CLEAR_ONE, 16'h1234, 8'h00, 16'd0));
        send(mk(KIND_READ, 16'h0000, 8'h00, 16'd3));          // room for the header only
        send(mk(KIND_READ, 16'h0000, 8'h00, 16'd5));          // exactly one entry fits
        send(mk(KIND_READ, 16'h0000, 8'h00, 16'hFFFF));
        send(mk(KIND_SPARE_LO, 16'h0000, 8'h00, 16'd0));
        send(mk(KIND_SPARE_HI, 16'hFFFF, 8'hFF, 16'hFFFF));
        send(mk(KIND_REPORT, 16'h5A5A, 8'h00, 16'd0));
        settle(4);

        // every code enabled, so the log can be filled to the top
        load_config({16'h5A5A, 16'hBEEF, 16'h0D0D, 16'h1234, 16'hFFFF, 16'h0000}, 6'h3F);
        send(mk(KIND_REPORT, 16'hBEEF, 8'h00, 16'd0));
        send(mk(KIND_REPORT, 16'h0D0D, 8'h00, 16'd0));        // last free slot
        send(mk(KIND_REPORT, 16'h7777, 8'h00, 16'd0));        // log full wins over unknown
        send(mk(KIND_REPORT, 16'h1234, 8'h00, 16'd0));        // cleared entry still counts
        send(mk(KIND_READ, 16'h0000, 8'h00, 16'd20));
        send(mk(KIND_READ, 16'h0000, 8'h00, 16'd16));         // last active entry cut off
        send(mk(KIND_CLEAR_ALL, 16'h0000, 8'h00, 16'd0));
        send(mk(KIND_REPORT, 16'h0D0D, 8'h00, 16'd0));        // refill after the wipe
        settle(4);

        // random, no idling, fresh codes all enabled
        for (int j = 0; j < KNOWN_CODES; j++) codes[j] = CODE_W'($urandom);
        load_config(codes, 6'h3F);
        for (int n = 0; n < PHASE_ITEMS; n++) send(random_cmd(1'b1));
        settle(4);

        // sender gaps; nothing enabled, so only codes already logged get anywhere
        idle_pct = 48;
        load_config({KNOWN_CODES{16'hFFFF}}, 6'h00);
        for (int n = 0; n < PHASE_ITEMS; n++) send(random_cmd(1'b1));
        settle(4);

        // receiver stalls; small code pool with duplicates and a random mask
        idle_pct  = 0;
        stall_pct = 48;
        for (int j = 0; j < KNOWN_CODES; j++) codes[j] = CODE_W'($urandom_range(0, 3));
        load_config(codes, KNOWN_CODES'($urandom_range(0, 63)));
        // long hold-off while items keep coming, so the block backs up into its input
        hold_asks++;
        send(mk(KIND_READ, 16'h0000, 8'h00, 16'hFFFF));
        for (int n = 0; n < PHASE_ITEMS; n++) send(random_cmd(1'b1));
        settle(4);

        // both sides idle; one code hammered until its count saturates, no wipes
        idle_pct  = 17;
        stall_pct = 17;
        for (int j = 0; j < KNOWN_CODES; j++) codes[j] = CODE_W'($urandom);
        load_config(codes, 6'h3F);
        hot = codes[0];
        send(mk(KIND_CLEAR_ALL, 16'h0000, 8'h00, 16'd0));
        send(mk(KIND_REPORT, hot, 8'h00, 16'd0));
        hot_sent = 1;
        while (hot_sent < HOT_REPORTS) begin
            if ($urandom_range(99) < 88) begin
                send(mk(KIND_REPORT, hot, 8'h00, 16'd0));
                hot_sent++;
            end else begin
                send(random_cmd(1'b0));
            end
        end
        send(mk(KIND_READ, 16'h0000, 8'h00, 16'hFFFF));

        // drain, then a margin for anything the block should not have sent
        settle(DRAIN_CYCLES);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
